### rtl/slsfr_pkg.sv
// Shared types, constants and helpers of the sync-word frame receiver.
package slsfr_pkg;

    localparam int MAX_FRAME_BYTES_DEF   = 64;
    localparam int MAX_PAYLOAD_BYTES_DEF = 50;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 40;

    localparam logic [7:0] SYNC_B0 = 8'hFA;
    localparam logic [7:0] SYNC_B1 = 8'hF5;
    localparam logic [7:0] SYNC_B2 = 8'hAA;
    localparam logic [7:0] SYNC_B3 = 8'hA5;

    localparam logic [15:0] SYNC_SUM = {8'h00, SYNC_B0} + {8'h00, SYNC_B1}
                                     + {8'h00, SYNC_B2} + {8'h00, SYNC_B3};

    // Byte positions within a frame, counted from the first sync byte.
    localparam logic [15:0] POS_BODY    = 16'd4;
    localparam logic [15:0] POS_LEN_LO  = 16'd4;
    localparam logic [15:0] POS_LEN_HI  = 16'd5;
    localparam logic [15:0] POS_TYPE    = 16'd7;
    localparam logic [15:0] POS_CMD     = 16'd8;
    localparam logic [15:0] POS_RESP    = 16'd9;
    localparam logic [15:0] POS_DL_LO   = 16'd10;
    localparam logic [15:0] POS_DL_HI   = 16'd11;
    localparam logic [15:0] POS_PAYLOAD = 16'd12;

    localparam logic [15:0] MIN_FRAME_LEN = 16'd12;
    localparam logic [15:0] MIN_DATA_LEN  = 16'd4;
    localparam logic [16:0] LEN_OVERHEAD  = 17'd10;

    typedef enum logic [1:0] {
        STAT_GOOD = 2'd0,
        STAT_SYNC = 2'd1,
        STAT_LEN  = 2'd2
    } status_t;

    typedef enum logic {
        PH_HUNT = 1'b0,
        PH_BODY = 1'b1
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_ERR,
        S_EMPTY,
        S_FETCH,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic    accept;
        logic    load_err;
        status_t err_code;
        logic    load_empty;
        logic    rd_clear;
        logic    load_pay;
    } ctrl_cmd_t;

    typedef struct packed {
        logic timeout;
        logic hunting;
        logic len_err;
        logic frame_end;
        logic sum_ok;
        logic len_ok;
        logic count_zero;
        logic rd_last;
        logic out_free;
    } dp_stat_t;

    function automatic logic [7:0] sync_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = SYNC_B0;
            2'd1:    b = SYNC_B1;
            2'd2:    b = SYNC_B2;
            default: b = SYNC_B3;
        endcase
        return b;
    endfunction

endpackage

### rtl/slsfr_dp.sv
// Datapath: sync hunt, header capture, checksum, payload memory and output register.
module slsfr_dp
    import slsfr_pkg::*;
#(
    parameter int MAX_FRAME_BYTES   = MAX_FRAME_BYTES_DEF,
    parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  ctrl_cmd_t  cmd_i,
    output dp_stat_t   stat_o,
    input  logic       in_cmd,
    input  logic [7:0] in_byte,
    input  logic       m_tready,
    output logic       out_valid,
    output status_t    out_status,
    output logic [7:0] out_type,
    output logic [7:0] out_command,
    output logic [7:0] out_response,
    output logic [5:0] out_plen,
    output logic [7:0] out_byte,
    output logic       out_last
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CNT_W = $clog2(MAX_PAYLOAD_BYTES + 1);
    localparam int IDX_W = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1;
    localparam int OFF_W = (POS_W > CNT_W) ? POS_W : CNT_W;

    phase_t           phase_reg, phase_next;
    logic [1:0]       sync_idx_reg, sync_idx_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      tl_reg, tl_next;
    logic [7:0]       type_reg, type_next;
    logic [7:0]       code_reg, code_next;
    logic [7:0]       resp_reg, resp_next;
    logic [15:0]      dl_reg, dl_next;
    logic [15:0]      rsum_reg, rsum_next;
    logic [15:0]      csum_reg, csum_next;

    logic [7:0]       mem [MAX_PAYLOAD_BYTES];
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [7:0]       rd_data_reg;

    logic             out_valid_reg, out_valid_next;
    status_t          out_status_reg, out_status_next;
    logic [7:0]       out_type_reg, out_type_next;
    logic [7:0]       out_command_reg, out_command_next;
    logic [7:0]       out_response_reg, out_response_next;
    logic [5:0]       out_plen_reg, out_plen_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;

    logic [15:0]      p16;
    logic [16:0]      p17;
    logic [16:0]      tl17;
    logic             in_cksum;
    logic             cksum_low;
    logic             at_end;
    logic             bad_tl;
    logic [OFF_W-1:0] off;
    logic             pay_wr;
    logic             body_byte;
    logic [15:0]      dl_m4;
    logic [CNT_W-1:0] count;
    logic             out_free;

    assign p16       = 16'(pos_reg);
    assign p17       = 17'(pos_reg);
    assign tl17      = {1'b0, tl_reg};
    assign in_cksum  = (p16 >= POS_CMD) && ((p17 + 17'd2) >= tl17);
    assign cksum_low = ((p17 + 17'd2) == tl17);
    assign at_end    = (p16 >= POS_CMD) && ((p17 + 17'd1) >= tl17);
    assign bad_tl    = (tl_reg < MIN_FRAME_LEN) || (tl_reg > 16'(MAX_FRAME_BYTES));
    assign off       = OFF_W'(pos_reg) - OFF_W'(POS_PAYLOAD);
    assign pay_wr    = (p16 >= POS_PAYLOAD) && ((p17 + 17'd2) < tl17)
                       && (off < OFF_W'(MAX_PAYLOAD_BYTES));
    assign body_byte = cmd_i.accept && !in_cmd && (phase_reg == PH_BODY);
    assign dl_m4     = dl_reg - MIN_DATA_LEN;
    assign count     = dl_m4[CNT_W-1:0];
    assign out_free  = !out_valid_reg || m_tready;

    always_comb begin
        stat_o.timeout    = in_cmd;
        stat_o.hunting    = (phase_reg == PH_HUNT);
        stat_o.len_err    = (phase_reg == PH_BODY) && !in_cmd && (p16 == POS_TYPE) && bad_tl;
        stat_o.frame_end  = (phase_reg == PH_BODY) && !in_cmd && at_end;
        stat_o.sum_ok     = (rsum_reg == csum_reg);
        stat_o.len_ok     = (dl_reg >= MIN_DATA_LEN)
                            && (dl_m4 <= 16'(MAX_PAYLOAD_BYTES))
                            && (({1'b0, dl_reg} + LEN_OVERHEAD) == tl17);
        stat_o.count_zero = (dl_reg == MIN_DATA_LEN);
        stat_o.rd_last    = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == count);
        stat_o.out_free   = out_free;
    end

    // Frame state: one request per accepted item.
    always_comb begin
        phase_next    = phase_reg;
        sync_idx_next = sync_idx_reg;
        pos_next      = pos_reg;
        tl_next       = tl_reg;
        type_next     = type_reg;
        code_next     = code_reg;
        resp_next     = resp_reg;
        dl_next       = dl_reg;
        rsum_next     = rsum_reg;
        csum_next     = csum_reg;
        if (cmd_i.accept) begin
            if (in_cmd) begin
                phase_next    = PH_HUNT;
                sync_idx_next = 2'd0;
                pos_next      = '0;
            end else if (phase_reg == PH_HUNT) begin
                if (in_byte == sync_byte(sync_idx_reg)) begin
                    if (sync_idx_reg == 2'd3) begin
                        phase_next    = PH_BODY;
                        sync_idx_next = 2'd0;
                        pos_next      = POS_W'(POS_BODY);
                        rsum_next     = SYNC_SUM;
                        csum_next     = '0;
                        tl_next       = '0;
                        dl_next       = '0;
                    end else begin
                        sync_idx_next = sync_idx_reg + 2'd1;
                    end
                end else begin
                    sync_idx_next = (in_byte == SYNC_B0) ? 2'd1 : 2'd0;
                end
            end else begin
                // The checksum bytes may overlap the header in very short frames.
                if (in_cksum) begin
                    if (cksum_low) begin
                        csum_next = {csum_reg[15:8], in_byte};
                    end else begin
                        csum_next = {in_byte, csum_reg[7:0]};
                    end
                end else begin
                    rsum_next = rsum_reg + {8'h00, in_byte};
                end
                case (p16)
                    POS_LEN_LO: tl_next   = {tl_reg[15:8], in_byte};
                    POS_LEN_HI: tl_next   = {in_byte, tl_reg[7:0]};
                    POS_TYPE:   type_next = in_byte;
                    POS_CMD:    code_next = in_byte;
                    POS_RESP:   resp_next = in_byte;
                    POS_DL_LO:  dl_next   = {dl_reg[15:8], in_byte};
                    POS_DL_HI:  dl_next   = {in_byte, dl_reg[7:0]};
                    default:    ;
                endcase
                if (stat_o.len_err || at_end) begin
                    phase_next    = PH_HUNT;
                    sync_idx_next = 2'd0;
                    pos_next      = '0;
                end else begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
        end
    end

    always_comb begin
        rd_idx_next = rd_idx_reg;
        if (cmd_i.rd_clear) begin
            rd_idx_next = '0;
        end else if (cmd_i.load_pay) begin
            rd_idx_next = rd_idx_reg + IDX_W'(1);
        end
    end

    always_comb begin
        out_valid_next    = out_valid_reg;
        out_status_next   = out_status_reg;
        out_type_next     = out_type_reg;
        out_command_next  = out_command_reg;
        out_response_next = out_response_reg;
        out_plen_next     = out_plen_reg;
        out_byte_next     = out_byte_reg;
        out_last_next     = out_last_reg;
        if (cmd_i.load_err) begin
            out_valid_next    = 1'b1;
            out_status_next   = cmd_i.err_code;
            out_type_next     = '0;
            out_command_next  = '0;
            out_response_next = '0;
            out_plen_next     = '0;
            out_byte_next     = '0;
            out_last_next     = 1'b1;
        end else if (cmd_i.load_empty) begin
            out_valid_next    = 1'b1;
            out_status_next   = STAT_GOOD;
            out_type_next     = type_reg;
            out_command_next  = code_reg;
            out_response_next = resp_reg;
            out_plen_next     = '0;
            out_byte_next     = '0;
            out_last_next     = 1'b1;
        end else if (cmd_i.load_pay) begin
            out_valid_next    = 1'b1;
            out_status_next   = STAT_GOOD;
            out_type_next     = type_reg;
            out_command_next  = code_reg;
            out_response_next = resp_reg;
            out_plen_next     = 6'(count);
            out_byte_next     = rd_data_reg;
            out_last_next     = stat_o.rd_last;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HUNT;
            sync_idx_reg  <= 2'd0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            sync_idx_reg  <= sync_idx_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tl_reg           <= tl_next;
        type_reg         <= type_next;
        code_reg         <= code_next;
        resp_reg         <= resp_next;
        dl_reg           <= dl_next;
        rsum_reg         <= rsum_next;
        csum_reg         <= csum_next;
        rd_idx_reg       <= rd_idx_next;
        out_status_reg   <= out_status_next;
        out_type_reg     <= out_type_next;
        out_command_reg  <= out_command_next;
        out_response_reg <= out_response_next;
        out_plen_reg     <= out_plen_next;
        out_byte_reg     <= out_byte_next;
        out_last_reg     <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (body_byte && pay_wr) begin
            mem[off[IDX_W-1:0]] <= in_byte;
        end
        rd_data_reg <= mem[rd_idx_reg];
    end

    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_type     = out_type_reg;
    assign out_command  = out_command_reg;
    assign out_response = out_response_reg;
    assign out_plen     = out_plen_reg;
    assign out_byte     = out_byte_reg;
    assign out_last     = out_last_reg;

    // A result is only ever loaded into a free output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_i.load_err || cmd_i.load_empty || cmd_i.load_pay) |-> out_free)
        else $error("output register overwritten");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd_i.load_err, cmd_i.load_empty, cmd_i.load_pay}))
        else $error("more than one result loaded at once");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_i.accept && in_cmd) |=> (phase_reg == PH_HUNT && sync_idx_reg == 2'd0))
        else $error("timeout did not restart the hunt");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_i.accept && stat_o.frame_end) |=> (phase_reg == PH_HUNT && pos_reg == '0))
        else $error("frame end did not restart the hunt");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_i.load_pay |-> (CNT_W'(rd_idx_reg) < count))
        else $error("payload read beyond the frame's byte count");

endmodule

### rtl/slsfr_ctrl.sv
// Controller: sequences byte intake, the end-of-frame check and result emission.
module slsfr_ctrl
    import slsfr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  dp_stat_t  stat_i,
    output ctrl_cmd_t cmd_o
);

    state_t  state_reg, state_next;
    status_t err_code_reg, err_code_next;

    always_comb begin
        state_next    = state_reg;
        err_code_next = err_code_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (stat_i.timeout) begin
                        err_code_next = stat_i.hunting ? STAT_SYNC : STAT_LEN;
                        state_next    = S_ERR;
                    end else if (stat_i.len_err) begin
                        err_code_next = STAT_LEN;
                        state_next    = S_ERR;
                    end else if (stat_i.frame_end) begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                // The sum is judged before the lengths.
                if (!stat_i.sum_ok) begin
                    err_code_next = STAT_SYNC;
                    state_next    = S_ERR;
                end else if (!stat_i.len_ok) begin
                    err_code_next = STAT_LEN;
                    state_next    = S_ERR;
                end else if (stat_i.count_zero) begin
                    state_next = S_EMPTY;
                end else begin
                    state_next = S_FETCH;
                end
            end
            S_ERR: begin
                if (stat_i.out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_EMPTY: begin
                if (stat_i.out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_FETCH: begin
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (stat_i.out_free) begin
                    state_next = stat_i.rd_last ? S_IDLE : S_FETCH;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready         = (state_reg == S_IDLE);
        cmd_o.accept     = (state_reg == S_IDLE) && s_tvalid;
        cmd_o.load_err   = (state_reg == S_ERR) && stat_i.out_free;
        cmd_o.err_code   = err_code_reg;
        cmd_o.load_empty = (state_reg == S_EMPTY) && stat_i.out_free;
        cmd_o.rd_clear   = (state_reg == S_CHECK);
        cmd_o.load_pay   = (state_reg == S_EMIT) && stat_i.out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        err_code_reg <= err_code_next;
    end

endmodule

### rtl/sync_length_sum_frame_receiver.sv
// Top level of the sync-word framed receiver with additive checksum.
//
//  Channel  | Direction | tdata (low bit up)                          | tuser     | tlast
//  s_ input | in        | rx_byte                                     | cmd       | -
//  m_ result| out       | frame_type, command_code, response_code,    | status    | last
//           |           | payload_len, payload_byte, 2 zero bits      |           |
//
// Received bytes and timeouts are accepted only in the idle state. After a frame's
// last byte the block checks sum and lengths, then per payload result reads the
// payload memory and loads the output register; an error or empty frame is loaded
// directly. No request is accepted during check and emission. Reset is synchronous
// and leaves the block hunting for sync; the payload memory needs no clearing. A
// stalled output only holds the block once a result waits.
module sync_length_sum_frame_receiver
    import slsfr_pkg::*;
#(
    parameter int MAX_FRAME_BYTES   = MAX_FRAME_BYTES_DEF,
    parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] rx_byte
    input  logic                 s_tuser,   // [0] cmd
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [7:0] frame_type, [15:8] command_code,
                                            // [23:16] response_code, [29:24] payload_len,
                                            // [37:30] payload_byte, [39:38] zero
    output logic [1:0]           m_tuser,   // [1:0] status
    output logic                 m_tlast    // last
);

    ctrl_cmd_t  cmd;
    dp_stat_t   stat;
    status_t    out_status;
    logic [7:0] out_type;
    logic [7:0] out_command;
    logic [7:0] out_response;
    logic [5:0] out_plen;
    logic [7:0] out_byte;

    slsfr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat_i   (stat),
        .cmd_o    (cmd)
    );

    slsfr_dp #(
        .MAX_FRAME_BYTES   (MAX_FRAME_BYTES),
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_i        (cmd),
        .stat_o       (stat),
        .in_cmd       (s_tuser),
        .in_byte      (s_tdata),
        .m_tready     (m_tready),
        .out_valid    (m_tvalid),
        .out_status   (out_status),
        .out_type     (out_type),
        .out_command  (out_command),
        .out_response (out_response),
        .out_plen     (out_plen),
        .out_byte     (out_byte),
        .out_last     (m_tlast)
    );

    assign m_tdata = {2'b00, out_byte, out_plen, out_response, out_command, out_type};
    assign m_tuser = out_status;

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// Testbench for the sync-word frame receiver: directed and random frames against a predictor.
module tb;
    import slsfr_pkg::*;

    localparam int MAX_FRAME          = MAX_FRAME_BYTES_DEF;
    localparam int MAX_PAYLOAD        = MAX_PAYLOAD_BYTES_DEF;
    localparam int CYCLE_LIMIT        = 400000;
    localparam int ITEM_COUNT         = 470;
    localparam int SETTLE_CYCLES      = 16;
    localparam logic [31:0] SYNC_WORD = {SYNC_B3, SYNC_B2, SYNC_B1, SYNC_B0};

    typedef enum {
        FR_GOOD,
        FR_EMPTY,
        FR_FULL,
        FR_BAD_SUM,
        FR_BAD_DATA_LEN,
        FR_BAD_TOTAL,
        FR_SHORT,
        FR_CUT,
        FR_NOISE
    } frame_kind_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] ftype;
        logic [7:0] cmd_code;
        logic [7:0] resp_code;
        logic [5:0] plen;
        logic [7:0] pbyte;
        logic       last;
    } frame_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;

    sync_length_sum_frame_receiver DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Predictor state, mirroring the receiver after reset.
    phase_t      rx_phase  = PH_HUNT;
    logic [2:0]  sync_idx  = '0;
    logic [15:0] byte_pos  = '0;
    logic [15:0] tot_len   = '0;
    logic [15:0] dl_hold   = '0;
    logic [15:0] run_sum   = '0;
    logic [15:0] rcv_sum   = '0;
    logic [7:0]  type_hold = '0;
    logic [7:0]  cmd_hold  = '0;
    logic [7:0]  resp_hold = '0;
    logic [7:0]  payload_mem [MAX_PAYLOAD];

    frame_result_t rx_results_due[$];
    int sent_events       = 0;
    int mismatch_count    = 0;
    int cycle_count       = 0;
    int burst_left        = 0;
    bit gaps_on           = 1'b1;

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    function automatic void return_to_hunt();
        rx_phase = PH_HUNT;
        sync_idx = '0;
        byte_pos = '0;
    endfunction

    function automatic void report_error(input status_t st);
        rx_results_due.push_back('{st, 8'h00, 8'h00, 8'h00, 6'd0, 8'h00, 1'b1});
        return_to_hunt();
    endfunction

    // End of frame: sum first, then the three length rules.
    function automatic void release_frame();
        int dl;
        int count;
        dl = dl_hold;
        if (run_sum != rcv_sum) begin
            report_error(STAT_SYNC);
        end else if (dl < MIN_DATA_LEN || dl - MIN_DATA_LEN > MAX_PAYLOAD
                     || dl + LEN_OVERHEAD != tot_len) begin
            report_error(STAT_LEN);
        end else begin
            count = dl - MIN_DATA_LEN;
            if (count == 0) begin
                rx_results_due.push_back('{STAT_GOOD, type_hold, cmd_hold, resp_hold,
                                           6'd0, 8'h00, 1'b1});
            end else begin
                for (int k = 0; k < count; k++) begin
                    rx_results_due.push_back('{STAT_GOOD, type_hold, cmd_hold, resp_hold,
                                               6'(count), payload_mem[k], k == count - 1});
                end
            end
            return_to_hunt();
        end
    endfunction

    function automatic void decode_rx_event(input logic timeout, input logic [7:0] b);
        int p;
        if (timeout) begin
            if (rx_phase == PH_HUNT) begin
                report_error(STAT_SYNC);
            end else begin
                report_error(STAT_LEN);
            end
            return;
        end
        if (rx_phase == PH_HUNT) begin
            if (b == SYNC_WORD[sync_idx[1:0]*8 +: 8]) begin
                sync_idx = sync_idx + 3'd1;
                if (sync_idx == 3'd4) begin
                    rx_phase = PH_BODY;
                    sync_idx = '0;
                    byte_pos = POS_BODY;
                    run_sum  = SYNC_SUM;
                    rcv_sum  = '0;
                    tot_len  = '0;
                    dl_hold  = '0;
                end
            end else begin
                sync_idx = (b == SYNC_B0) ? 3'd1 : 3'd0;
            end
            return;
        end
        p = byte_pos;
        // For very short frames the checksum bytes land on header positions.
        if (p >= POS_CMD && p + 2 >= tot_len) begin
            if (p + 2 == tot_len) begin
                rcv_sum[7:0] = b;
            end else begin
                rcv_sum[15:8] = b;
            end
        end else begin
            run_sum = run_sum + {8'h00, b};
        end
        case (p)
            POS_LEN_LO: tot_len[7:0]  = b;
            POS_LEN_HI: tot_len[15:8] = b;
            POS_TYPE:   type_hold     = b;
            POS_CMD:    cmd_hold      = b;
            POS_RESP:   resp_hold     = b;
            POS_DL_LO:  dl_hold[7:0]  = b;
            POS_DL_HI:  dl_hold[15:8] = b;
            default: begin
                if (p >= POS_PAYLOAD && p + 2 < tot_len && p - POS_PAYLOAD < MAX_PAYLOAD) begin
                    payload_mem[p - POS_PAYLOAD] = b;
                end
            end
        endcase
        if (p == POS_TYPE && (tot_len < MIN_FRAME_LEN || tot_len > MAX_FRAME)) begin
            report_error(STAT_LEN);
            return;
        end
        if (p >= POS_CMD && p + 1 >= tot_len) begin
            release_frame();
            return;
        end
        byte_pos = 16'(p + 1);
    endfunction

    // Sends one request in bursts, with random gaps while gaps are on, and predicts once it is taken.
    task automatic send_event(input logic timeout, input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            if (gaps_on) begin
                gap = $urandom_range(1, 6);
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= timeout;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        decode_rx_event(timeout, b);
        sent_events++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (rx_results_due.size() != 0) @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic send_frame(input frame_kind_t kind);
        int n;
        int tot;
        int dl;
        int cnt;
        logic [15:0] sum;
        logic [7:0]  fb[$];
        if (kind == FR_NOISE) begin
            // Noise rich in first sync bytes, sometimes closed by a timeout.
            repeat ($urandom_range(1, 8)) begin
                send_event(1'b0, ($urandom_range(0, 2) == 0) ? SYNC_B0 : 8'($urandom));
            end
            if ($urandom_range(0, 3) == 0) send_event(1'b1, 8'($urandom));
            return;
        end
        case (kind)
            FR_EMPTY, FR_SHORT: n = 0;
            FR_FULL:            n = MAX_PAYLOAD;
            default: n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_PAYLOAD)
                                                     : $urandom_range(1, 8);
        endcase
        tot = n + 14;
        dl  = n + 4;
        if (kind == FR_BAD_DATA_LEN) begin
            case ($urandom_range(0, 2))
                0:       dl = $urandom_range(0, 3);
                1:       dl = ($urandom_range(0, 1) == 1) ? n + 4 + $urandom_range(1, 8)
                                                          : n + 4 - $urandom_range(1, n + 4);
                default: dl = $urandom_range(MAX_PAYLOAD + 5, 65535);
            endcase
        end else if (kind == FR_BAD_TOTAL) begin
            tot = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 11)
                                              : $urandom_range(MAX_FRAME + 1, 65535);
        end else if (kind == FR_SHORT) begin
            tot = $urandom_range(12, 13);
        end
        fb = {SYNC_B0, SYNC_B1, SYNC_B2, SYNC_B3, 8'(tot), 8'(tot >> 8),
              8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'(dl), 8'(dl >> 8)};
        repeat (n) fb.push_back(8'($urandom));
        sum = '0;
        foreach (fb[i]) sum = sum + {8'h00, fb[i]};
        if (kind == FR_BAD_SUM) sum = sum ^ 16'($urandom_range(1, 65535));
        fb.push_back(sum[7:0]);
        fb.push_back(sum[15:8]);
        cnt = (tot < MIN_FRAME_LEN || tot > MAX_FRAME) ? POS_TYPE + 1 : tot;
        if (kind == FR_CUT) cnt = $urandom_range(0, fb.size() - 1);
        for (int i = 0; i < cnt; i++) begin
            send_event(1'b0, (i < fb.size()) ? fb[i] : 8'($urandom));
        end
        if (kind == FR_CUT) send_event(1'b1, 8'($urandom));
    endtask

    // Timeouts while hunting and inside a frame, and sync restarts on a stray first byte.
    task automatic test_sync_hunt();
        send_event(1'b1, 8'($urandom));
        send_event(1'b0, SYNC_B0);
        send_event(1'b0, SYNC_B0);
        send_event(1'b0, SYNC_B1);
        send_event(1'b0, SYNC_B2);
        send_event(1'b0, SYNC_B3);
        send_event(1'b1, 8'($urandom));
        send_event(1'b0, SYNC_B0);
        send_event(1'b0, SYNC_B1);
        send_event(1'b0, SYNC_B2);
        send_event(1'b0, SYNC_B0);
        send_event(1'b0, SYNC_B1);
        send_event(1'b0, SYNC_B2);
        send_event(1'b0, SYNC_B3);
        send_event(1'b1, 8'($urandom));
    endtask

    task automatic test_empty_frame();
        send_frame(FR_EMPTY);
    endtask

    // Rounds that hold every kind of frame, good ones four times and the others once, in random order.
    task automatic test_random_frames();
        frame_kind_t round[$];
        int rounds;
        int idx;
        rounds = 0;
        while (sent_events < ITEM_COUNT) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            round = {FR_GOOD, FR_GOOD, FR_GOOD, FR_GOOD, FR_EMPTY, FR_FULL, FR_BAD_SUM,
                     FR_BAD_DATA_LEN, FR_BAD_TOTAL, FR_SHORT, FR_CUT, FR_NOISE};
            while (round.size() > 0 && sent_events < ITEM_COUNT) begin
                idx = $urandom_range(0, round.size() - 1);
                send_frame(round[idx]);
                round.delete(idx);
            end
            if (rounds == 0 || $urandom_range(0, 2) == 0) wait_drained();
            rounds++;
        end
    endtask

    // Receiver ready patterns, some with stalls, switching to a new random pattern after a random hold.
    initial begin
        int mode;
        int hold;
        int tick;
        mode = 0;
        hold = 0;
        tick = 0;
        forever begin
            @(negedge aclk);
            if (hold == 0) begin
                mode = $urandom_range(0, 3);
                hold = $urandom_range(40, 300);
            end
            hold--;
            tick++;
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (tick % 8 < 5);
            endcase
        end
    end

    always @(posedge aclk) begin
        frame_result_t want;
        logic [M_TDATA_W-1:0] want_data;
        if (aresetn && m_tvalid && m_tready) begin
            if (rx_results_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("tb: result with none due: tuser=%0d tdata=%h tlast=%b",
                             m_tuser, m_tdata, m_tlast);
                end
            end else begin
                want      = rx_results_due.pop_front();
                want_data = {2'b00, want.pbyte, want.plen, want.resp_code, want.cmd_code,
                             want.ftype};
                if (m_tuser !== want.status || m_tdata !== want_data
                    || m_tlast !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("tb: mismatch: expected tuser=%0d tdata=%h tlast=%b,",
                                 want.status, want_data, want.last,
                                 " got tuser=%0d tdata=%h tlast=%b",
                                 m_tuser, m_tdata, m_tlast);
                    end
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_sync_hunt();
        test_empty_frame();
        test_random_frames();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (rx_results_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && rx_results_due.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
